// File: design/mjd_date_converter_assert.svh
// assertion macros used by the mjd converter pipeline control
`ifndef MJD_DATE_CONVERTER_ASSERT_SVH
`define MJD_DATE_CONVERTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MJD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mjd converter check failed");

// antecedent implies consequent in the next cycle
`define MJD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mjd converter check failed");

`endif

// File: design/mjd_pkg.sv
// types, constants and the month term table of the mjd converter
package mjd_pkg;

    localparam int NUM_STAGES = 8;

    typedef enum logic [1:0] {
        OP_MJD  = 2'd0,
        OP_ENC  = 2'd1,
        OP_DAYS = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic [15:0] MJD_WRAP_LIMIT = 16'd15079;
    localparam logic [16:0] MJD_WRAP_ADD   = 17'h10000;
    localparam logic [16:0] MJD_EPOCH_2000 = 17'd51544;
    localparam logic [23:0] YEAR_NUM_BIAS  = 24'd1507820;
    localparam logic [39:0] YEAR_RECIP     = 40'd117589;
    localparam logic [23:0] YEAR_DIV       = 24'd36525;
    localparam logic [17:0] DAY_BASE       = 18'd14956;
    localparam logic [23:0] MONTH_SCALE    = 24'd10000;
    localparam logic [23:0] MONTH_BIAS     = 24'd1000;
    localparam logic [37:0] MONTH_RECIP    = 38'd14035;
    localparam logic [24:0] MONTH_DIV      = 25'd306001;
    localparam logic [15:0] YTERM_MINUS1   = 16'hFE93;
    localparam logic [11:0] YEAR_BASE      = 12'd1900;

    // shared per-item fields carried along the pipe
    typedef struct packed {
        op_t         op;
        logic [2:0]  wd;
        logic [15:0] enc;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [16:0] u;
        logic [22:0] n1;
    } front_t;

    typedef struct packed {
        side_t       side;
        logic [16:0] u;
        logic [7:0]  y;
    } yr_t;

    typedef struct packed {
        side_t       side;
        logic [7:0]  y;
        logic [9:0]  w;
        logic [3:0]  m;
    } md_t;

    // floor(x * 30.6001)
    function automatic logic [8:0] month_term(input logic [4:0] x);
        logic [8:0] t;
        unique case (x)
            5'd0:    t = 9'd0;
            5'd1:    t = 9'd30;
            5'd2:    t = 9'd61;
            5'd3:    t = 9'd91;
            5'd4:    t = 9'd122;
            5'd5:    t = 9'd153;
            5'd6:    t = 9'd183;
            5'd7:    t = 9'd214;
            5'd8:    t = 9'd244;
            5'd9:    t = 9'd275;
            5'd10:   t = 9'd306;
            5'd11:   t = 9'd336;
            5'd12:   t = 9'd367;
            5'd13:   t = 9'd397;
            5'd14:   t = 9'd428;
            5'd15:   t = 9'd459;
            5'd16:   t = 9'd489;
            default: t = 9'd0;
        endcase
        return t;
    endfunction

endpackage

// File: design/mjd_ifs.sv
// request and result channel interfaces of the mjd converter
interface mjd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] day_number;
    logic [7:0]  year_offset;
    logic [3:0]  month_in;
    logic [4:0]  day_in;

    modport source (output valid, op, day_number, year_offset, month_in, day_in,
                    input ready);
    modport sink   (input valid, op, day_number, year_offset, month_in, day_in,
                    output ready);
endinterface

interface mjd_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [2:0]  week_day;
    logic [15:0] out_day_number;

    modport source (output valid, out_year, out_month, out_day, week_day, out_day_number,
                    input ready);
    modport sink   (input valid, out_year, out_month, out_day, week_day, out_day_number,
                    output ready);
endinterface

// File: design/mjd_pipe_ctrl.sv
// valid bits and per-stage advance of the mjd converter pipeline
`include "mjd_date_converter_assert.svh"

module mjd_pipe_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mjd_pkg::NUM_STAGES-1:0] adv
);
    import mjd_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic                  in_xfer;
    logic                  out_xfer;
    int                    fill_count;

    // a stage moves on when it is empty or the one after it moves on
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = adv[0];
    assign out_valid  = valid_reg[NUM_STAGES-1];
    assign in_xfer    = in_valid && in_ready;
    assign out_xfer   = out_valid && out_ready;
    assign fill_count = $countones(valid_reg);

    `MJD_ASSERT_SAME(a_full_when_blocked, !in_ready, (&valid_reg) && !out_ready)
    `MJD_ASSERT_NEXT(a_entry_lands, in_xfer, valid_reg[0])
    `MJD_ASSERT_NEXT(a_count_up, in_xfer && !out_xfer, fill_count == $past(fill_count) + 1)
    `MJD_ASSERT_NEXT(a_count_down, out_xfer && !in_xfer, fill_count + 1 == $past(fill_count))

endmodule

// File: design/mjd_front.sv
// stage one: op decode, mjd wrap, year numerator and the date to mjd encode
module mjd_front (
    input  logic            clk,
    input  logic            adv,
    input  logic [1:0]      op,
    input  logic [15:0]     day_number,
    input  logic [7:0]      year_offset,
    input  logic [3:0]      month_in,
    input  logic [4:0]      day_in,
    output mjd_pkg::front_t stage
);
    import mjd_pkg::*;

    front_t      stage_reg;
    front_t      stage_next;
    op_t         op_c;
    logic [16:0] shifted;
    logic [15:0] mjd;
    logic [16:0] u;
    logic [23:0] n1_full;
    logic        lead;
    logic        neg_year;
    logic [7:0]  yt;
    logic [16:0] yterm_full;
    logic [15:0] yterm;
    logic [4:0]  midx;

    always_comb
    begin
        op_c    = op_t'(op);
        shifted = {1'b0, day_number} + MJD_EPOCH_2000;
        mjd     = (op_c == OP_DAYS) ? shifted[15:0] : day_number;
        // dates before 1900-03-01 are taken as wrapped
        u       = (mjd < MJD_WRAP_LIMIT) ? ({1'b0, mjd} + MJD_WRAP_ADD) : {1'b0, mjd};
        n1_full = 24'(u) * 24'd100 - YEAR_NUM_BIAS;

        // january and february count towards the previous year
        lead       = (month_in == 4'd1) || (month_in == 4'd2);
        neg_year   = (year_offset == 8'd0) && lead;
        yt         = year_offset - 8'(lead);
        yterm_full = 17'(yt) * 17'd365 + 17'(yt[7:2]);
        yterm      = neg_year ? YTERM_MINUS1 : yterm_full[15:0];
        midx       = 5'(month_in) + 5'd1 + (lead ? 5'd12 : 5'd0);

        stage_next.side.op  = op_c;
        stage_next.side.wd  = 3'd0;
        stage_next.side.enc = DAY_BASE[15:0] + 16'(day_in) + yterm + 16'(month_term(midx));
        stage_next.u        = u;
        stage_next.n1       = n1_full[22:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

// File: design/mjd_year_div.sv
// stages two and three: year quotient by reciprocal and correction, weekday
module mjd_year_div (
    input  logic            clk,
    input  logic [1:0]      adv,
    input  mjd_pkg::front_t front,
    output mjd_pkg::yr_t    stage
);
    import mjd_pkg::*;

    front_t      s2_reg;
    front_t      s2_next;
    logic [7:0]  q_reg;
    logic [7:0]  q_next;
    yr_t         stage_reg;
    yr_t         stage_next;
    logic [39:0] q_prod;
    logic [23:0] back_prod;
    logic [23:0] rem;

    // (v) mod 7 by folding octal digits, since 8 is 1 mod 7
    function automatic logic [2:0] mod7(input logic [16:0] v);
        logic [17:0] x;
        logic [5:0]  s1;
        logic [3:0]  s2;
        logic [2:0]  r;
        x  = {1'b0, v};
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
           + 6'(x[14:12]) + 6'(x[17:15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        priority if (s2 >= 4'd14)
        begin
            r = 3'd0;
        end
        else if (s2 >= 4'd7)
        begin
            r = 3'(s2 - 4'd7);
        end
        else
        begin
            r = s2[2:0];
        end
        return r;
    endfunction

    always_comb
    begin
        q_prod          = 40'(front.n1) * YEAR_RECIP;
        q_next          = q_prod[39:32];
        s2_next         = front;
        // sunday is zero
        s2_next.side.wd = mod7(front.u + 17'd3);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s2_reg <= s2_next;
            q_reg  <= q_next;
        end
    end

    // the estimate is low by at most one
    always_comb
    begin
        back_prod       = 24'(q_reg) * YEAR_DIV;
        rem             = 24'(s2_reg.n1) - back_prod;
        stage_next.side = s2_reg.side;
        stage_next.u    = s2_reg.u;
        stage_next.y    = q_reg + 8'(rem >= YEAR_DIV);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

// File: design/mjd_month_div.sv
// stages four to seven: day of year, month quotient by reciprocal and correction
module mjd_month_div (
    input  logic         clk,
    input  logic [3:0]   adv,
    input  mjd_pkg::yr_t yr,
    output mjd_pkg::md_t stage
);
    import mjd_pkg::*;

    md_t         s4_reg;
    md_t         s4_next;
    md_t         s5_reg;
    md_t         s5_next;
    logic [23:0] n2_reg;
    logic [23:0] n2_next;
    md_t         s6_reg;
    logic [23:0] n2_6_reg;
    logic [5:0]  q_reg;
    logic [5:0]  q_next;
    md_t         stage_reg;
    md_t         stage_next;
    logic [16:0] yterm;
    logic [17:0] w_full;
    logic [37:0] q_prod;
    logic [24:0] back_prod;
    logic [24:0] rem;
    logic [5:0]  m_full;

    // floor(y * 365.25) is 365y plus y/4 for a non-negative year
    always_comb
    begin
        yterm          = 17'(yr.y) * 17'd365 + 17'(yr.y[7:2]);
        w_full         = 18'(yr.u) - DAY_BASE - 18'(yterm);
        s4_next.side   = yr.side;
        s4_next.y      = yr.y;
        s4_next.w      = w_full[9:0];
        s4_next.m      = 4'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s4_reg <= s4_next;
        end
    end

    always_comb
    begin
        s5_next = s4_reg;
        n2_next = 24'(s4_reg.w) * MONTH_SCALE - MONTH_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s5_reg <= s5_next;
            n2_reg <= n2_next;
        end
    end

    always_comb
    begin
        q_prod = 38'(n2_reg) * MONTH_RECIP;
        q_next = q_prod[37:32];
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s6_reg   <= s5_reg;
            n2_6_reg <= n2_reg;
            q_reg    <= q_next;
        end
    end

    // the estimate is low by at most one
    always_comb
    begin
        back_prod    = 25'(q_reg) * MONTH_DIV;
        rem          = 25'(n2_6_reg) - back_prod;
        m_full       = q_reg + 6'(rem >= MONTH_DIV);
        stage_next   = s6_reg;
        stage_next.m = m_full[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

// File: design/mjd_date_converter.sv
// top level of the mjd date converter: pipeline control, stages and result register
//
// request channel: op selects the conversion. op 0 turns a 16-bit mjd into year,
// month, day and weekday; op 1 turns years since 1900, month and day into an
// mjd modulo 65536; op 2 adds the mjd of 2000-01-01 to a day count and then
// converts as op 0. an mjd below 15079 is read as wrapped past 65535.
// unused op code 3 gives a result with every field zero.
// result channel: one transfer per request, in request order. fields that do
// not belong to the chosen op read zero.
// path: a request goes through eight register stages (front, two for the year
// divide, four for day of year and the month divide, one result register) on
// its way to the result channel.
// throughput: one transfer per cycle while results are taken; each divide by a
// constant is a reciprocal multiply and a one-step correction in its own stage.
// stalls: a stage holds while the stage after it is full and held, so empty
// stages keep filling behind a stalled result; the request side drops ready
// only when all eight stages are full and the result is not taken.
// reset: clears every valid bit at once; nothing else needs clearing.
module mjd_date_converter (
    input  logic       clk,
    input  logic       rst_n,
    mjd_req_if.sink    request,
    mjd_rsp_if.source  result
);
    import mjd_pkg::*;

    logic [NUM_STAGES-1:0] adv;
    front_t                front;
    yr_t                   yr;
    md_t                   md;

    logic [11:0] out_year_reg;
    logic [11:0] out_year_next;
    logic [3:0]  out_month_reg;
    logic [3:0]  out_month_next;
    logic [4:0]  out_day_reg;
    logic [4:0]  out_day_next;
    logic [2:0]  week_day_reg;
    logic [2:0]  week_day_next;
    logic [15:0] out_day_number_reg;
    logic [15:0] out_day_number_next;

    logic        date_op;
    logic        late_month;
    logic [9:0]  day_full;
    logic [11:0] year_calc;
    logic [3:0]  month_calc;

    // handshake and stage advance
    mjd_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .adv       (adv)
    );

    mjd_front u_front (
        .clk         (clk),
        .adv         (adv[0]),
        .op          (request.op),
        .day_number  (request.day_number),
        .year_offset (request.year_offset),
        .month_in    (request.month_in),
        .day_in      (request.day_in),
        .stage       (front)
    );

    mjd_year_div u_year (
        .clk   (clk),
        .adv   (adv[2:1]),
        .front (front),
        .stage (yr)
    );

    mjd_month_div u_month (
        .clk   (clk),
        .adv   (adv[6:3]),
        .yr    (yr),
        .stage (md)
    );

    // months 14 and 15 of the march-based year are january and february
    always_comb
    begin
        date_op    = (md.side.op == OP_MJD) || (md.side.op == OP_DAYS);
        late_month = (md.m == 4'd14) || (md.m == 4'd15);
        day_full   = md.w - 10'(month_term({1'b0, md.m}));
        year_calc  = 12'(md.y) + 12'(late_month) + YEAR_BASE;
        month_calc = md.m - 4'd1 - (late_month ? 4'd12 : 4'd0);

        out_year_next       = date_op ? year_calc : 12'd0;
        out_month_next      = date_op ? month_calc : 4'd0;
        out_day_next        = date_op ? day_full[4:0] : 5'd0;
        week_day_next       = date_op ? md.side.wd : 3'd0;
        out_day_number_next = (md.side.op == OP_ENC) ? md.side.enc : 16'd0;
    end

    // result register, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (adv[NUM_STAGES-1])
        begin
            out_year_reg       <= out_year_next;
            out_month_reg      <= out_month_next;
            out_day_reg        <= out_day_next;
            week_day_reg       <= week_day_next;
            out_day_number_reg <= out_day_number_next;
        end
    end

    assign result.out_year       = out_year_reg;
    assign result.out_month      = out_month_reg;
    assign result.out_day        = out_day_reg;
    assign result.week_day       = week_day_reg;
    assign result.out_day_number = out_day_number_reg;

endmodule
